// File: design/p3ls_pkg.sv
package p3ls_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_FACTOR = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_NO_FACTOR = 2'd2;

    // arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SUB
    } alu_op_t;

endpackage

// File: design/pivoted_3x3_linear_solver.sv
// Channel  | Direction | tdata (low bit up)                         | tuser
// s_axis   | in        | row_select[1:0] value_a value_b value_c    | action[1:0]
// m_axis   | out       | sol_first sol_second sol_third             | status[1:0] from_solve
//
// A row write leaves s_tready high. Factor and solve run as a micro-program over
// one shared unit; each step is issued in S_OP, runs on the unit while S_WAIT waits
// for it and is written back when done; the divide makes one quotient bit a cycle
// and a zero divisor ends it early. A factor is 3 divides and 5 multiply-subtracts
// plus the pivot steps S_PIV0, F_PIV1 and F_END, a solve 3 divides and 6 multiply-subtracts.
// aresetn clears pivot order and status flags; the matrix store has no reset.
// For factor and solve, s_tready is low from acceptance until the result beat leaves m_axis.
module pivoted_3x3_linear_solver
    import p3ls_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // row_select, value_a, value_b, value_c, 6 pad
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // sol_first, sol_second, sol_third
    output logic [2:0]   m_tuser    // status, from_solve
);

    localparam int W = VALUE_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam int DN = W + F;             // dividend width
    localparam int DCNT = $clog2(DN + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] val_t;

    // saturate a 32-bit signed field into W bits
    function automatic val_t load_fld(input logic [31:0] f);
        logic signed [31:0] s;
        logic signed [64:0] e;
        s = f;
        e = 65'(s);
        if (e > 65'(VMAX)) return VMAX;
        if (e < 65'(VMIN)) return VMIN;
        return val_t'(e);
    endfunction

    function automatic logic [31:0] emit_fld(input val_t v);
        logic signed [64:0] e;
        e = 65'(v);
        if (e > 65'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (e < -65'sh80000000) return 32'h80000000;
        return e[31:0];
    endfunction

    function automatic logic [W-1:0] mag(input val_t v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // pack sign/magnitude with saturation; mag wider than W allowed
    function automatic val_t pack(input logic neg, input logic [2*W:0] m);
        logic [2*W:0] lim;
        lim = (2*W+1)'(1) << (W-1);
        if (neg) begin
            if (m > lim) return VMIN;
            return val_t'(~m + 1'b1);
        end
        if (m > lim - 1'b1) return VMAX;
        return val_t'(m);
    endfunction

    // address helpers
    function automatic logic [3:0] at(input logic [1:0] r, input logic [1:0] c);
        return 4'(r) * 4'd3 + 4'(c);
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] r, input logic [1:0] k);
        logic [2:0] s;
        s = 3'(r) + 3'(k);
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_PIV0, S_OP, S_WAIT, S_OUT
    } state_t;

    // micro-program steps
    typedef enum logic [4:0] {
        F_D01, F_D02, F_M11, F_S11, F_M12, F_S12, F_M21, F_S21, F_M22, F_S22,
        F_PIV1, F_D12, F_M2, F_S2, F_END,
        V_Y0, V_M1, V_S1, V_D1, V_M2A, V_S2A, V_M2B, V_S2B, V_D2,
        V_M3, V_S3, V_M4, V_S4, V_M5, V_S5, V_END
    } step_t;

    val_t mat [9];
    val_t rhs_reg [3];
    val_t t_reg [3];   // y0/x0, y1/x1, y2/x2
    logic [1:0] piv_reg [3];
    logic fact_reg, sing_reg;
    state_t state_reg;
    step_t step_reg;
    logic [1:0] p0_reg, p1_reg, p2_reg;

    logic [1:0] act_in, row_in;
    assign act_in = s_tuser;
    assign row_in = s_tdata[1:0];
    val_t va, vb, vc;
    assign va = load_fld(s_tdata[33:2]);
    assign vb = load_fld(s_tdata[65:34]);
    assign vc = load_fld(s_tdata[97:66]);

    // shared unit
    alu_op_t op_reg;
    val_t x_reg, y_reg, res_reg;
    logic neg_reg;
    logic [2*W-1:0] prod_reg;
    logic [W:0] rem_reg;
    logic [DN-1:0] num_reg;
    logic [DN-1:0] quo_reg;
    logic [W-1:0] den_reg;
    logic [DCNT-1:0] cnt_reg;
    logic busy_reg, done_reg;

    // operand select per step
    alu_op_t ua_op;
    val_t ua_x, ua_y;
    logic [1:0] i1, i2;
    assign i1 = inc3(p0_reg, 2'd1);
    assign i2 = inc3(p0_reg, 2'd2);

    logic [2*W:0] rnd;
    assign rnd = ({1'b0, prod_reg} + ((2*W+1)'(1) << (F-1))) >> F;

    logic [W:0] rsh;
    assign rsh = {rem_reg[W-1:0], num_reg[DN-1]};

    logic [W:0] smx, smy;
    logic sng;
    assign smx = {1'b0, mag(x_reg)};
    assign smy = {1'b0, mag(y_reg)};
    assign sng = ~y_reg[W-1];   // sign of -y

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            case (op_reg)
                OP_MUL: begin
                    res_reg <= pack(neg_reg, rnd);
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                OP_DIV: begin
                    if (den_reg == '0) begin
                        res_reg <= '0;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else if (cnt_reg == '0) begin
                        res_reg <= pack(neg_reg, (2*W+1)'(quo_reg));
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        done_reg <= 1'b0;
                        num_reg <= num_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                        if (rsh >= {1'b0, den_reg}) begin
                            rem_reg <= rsh - {1'b0, den_reg};
                            quo_reg <= {quo_reg[DN-2:0], 1'b1};
                        end else begin
                            rem_reg <= rsh;
                            quo_reg <= {quo_reg[DN-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                    if (x_reg[W-1] == sng)
                        res_reg <= pack(sng, (2*W+1)'(smx + smy));
                    else if (smx >= smy)
                        res_reg <= pack(x_reg[W-1], (2*W+1)'(smx - smy));
                    else
                        res_reg <= pack(sng, (2*W+1)'(smy - smx));
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            endcase
        end else if (state_reg == S_OP) begin
            done_reg <= 1'b0;
            busy_reg <= 1'b1;
            neg_reg <= ua_x[W-1] ^ ua_y[W-1];
            x_reg <= ua_x;
            y_reg <= ua_y;
            op_reg <= ua_op;
            prod_reg <= mag(ua_x) * mag(ua_y);
            den_reg <= mag(ua_y);
            num_reg <= DN'(mag(ua_x)) << F;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= DCNT'(DN);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_comb begin
        ua_op = OP_SUB;
        ua_x = res_reg;
        ua_y = '0;
        case (step_reg)
            F_D01: begin ua_op = OP_DIV; ua_x = mat[at(p0_reg,1)]; ua_y = mat[at(p0_reg,0)]; end
            F_D02: begin ua_op = OP_DIV; ua_x = mat[at(p0_reg,2)]; ua_y = mat[at(p0_reg,0)]; end
            F_M11: begin ua_op = OP_MUL; ua_x = mat[at(i1,0)]; ua_y = mat[at(p0_reg,1)]; end
            F_S11: begin ua_x = mat[at(i1,1)]; ua_y = res_reg; end
            F_M12: begin ua_op = OP_MUL; ua_x = mat[at(i1,0)]; ua_y = mat[at(p0_reg,2)]; end
            F_S12: begin ua_x = mat[at(i1,2)]; ua_y = res_reg; end
            F_M21: begin ua_op = OP_MUL; ua_x = mat[at(i2,0)]; ua_y = mat[at(p0_reg,1)]; end
            F_S21: begin ua_x = mat[at(i2,1)]; ua_y = res_reg; end
            F_M22: begin ua_op = OP_MUL; ua_x = mat[at(i2,0)]; ua_y = mat[at(p0_reg,2)]; end
            F_S22: begin ua_x = mat[at(i2,2)]; ua_y = res_reg; end
            F_D12: begin ua_op = OP_DIV; ua_x = mat[at(p1_reg,2)]; ua_y = mat[at(p1_reg,1)]; end
            F_M2:  begin ua_op = OP_MUL; ua_x = mat[at(p2_reg,1)]; ua_y = mat[at(p1_reg,2)]; end
            F_S2:  begin ua_x = mat[at(p2_reg,2)]; ua_y = res_reg; end
            V_Y0:  begin ua_op = OP_DIV; ua_x = rhs_reg[p0_reg]; ua_y = mat[at(p0_reg,0)]; end
            V_M1:  begin ua_op = OP_MUL; ua_x = mat[at(p1_reg,0)]; ua_y = t_reg[0]; end
            V_S1:  begin ua_x = rhs_reg[p1_reg]; ua_y = res_reg; end
            V_D1:  begin ua_op = OP_DIV; ua_x = t_reg[1]; ua_y = mat[at(p1_reg,1)]; end
            V_M2A: begin ua_op = OP_MUL; ua_x = mat[at(p2_reg,1)]; ua_y = t_reg[1]; end
            V_S2A: begin ua_x = rhs_reg[p2_reg]; ua_y = res_reg; end
            V_M2B: begin ua_op = OP_MUL; ua_x = mat[at(p2_reg,0)]; ua_y = t_reg[0]; end
            V_S2B: begin ua_x = t_reg[2]; ua_y = res_reg; end
            V_D2:  begin ua_op = OP_DIV; ua_x = t_reg[2]; ua_y = mat[at(p2_reg,2)]; end
            V_M3:  begin ua_op = OP_MUL; ua_x = mat[at(p1_reg,2)]; ua_y = t_reg[2]; end
            V_S3:  begin ua_x = t_reg[1]; ua_y = res_reg; end
            V_M4:  begin ua_op = OP_MUL; ua_x = mat[at(p0_reg,1)]; ua_y = t_reg[1]; end
            V_S4:  begin ua_x = t_reg[0]; ua_y = res_reg; end
            V_M5:  begin ua_op = OP_MUL; ua_x = mat[at(p0_reg,2)]; ua_y = t_reg[2]; end
            V_S5:  begin ua_x = t_reg[0]; ua_y = res_reg; end
            default: ;
        endcase
    end

    // first pivot search over column 0
    logic [W-1:0] m0, m1, m2;
    assign m0 = mag(mat[0]);
    assign m1 = mag(mat[3]);
    assign m2 = mag(mat[6]);

    logic [1:0] sts_reg;
    logic fs_reg;
    logic s_hs, m_hs;
    assign s_hs = s_tvalid && s_tready;
    assign m_hs = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {emit_fld(t_reg[2]), emit_fld(t_reg[1]), emit_fld(t_reg[0])};
    assign m_tuser = {fs_reg, sts_reg};

    logic [W-1:0] ma, mb;
    assign ma = mag(mat[at(i1,1)]);
    assign mb = mag(mat[at(i2,1)]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg <= F_END;
            fact_reg <= 1'b0;
            sing_reg <= 1'b0;
            piv_reg <= '{2'd0, 2'd0, 2'd0};
            sts_reg <= ST_OK;
            fs_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_hs) begin
                        rhs_reg <= '{va, vb, vc};
                        t_reg <= '{'0, '0, '0};
                        p0_reg <= piv_reg[0];
                        p1_reg <= piv_reg[1];
                        p2_reg <= piv_reg[2];
                        case (act_in)
                            ACT_WRITE: begin
                                if (row_in != 2'd3) begin
                                    mat[at(row_in,0)] <= va;
                                    mat[at(row_in,1)] <= vb;
                                    mat[at(row_in,2)] <= vc;
                                    fact_reg <= 1'b0;
                                    sing_reg <= 1'b0;
                                end
                            end
                            ACT_FACTOR: begin
                                fs_reg <= 1'b0;
                                state_reg <= S_PIV0;
                            end
                            ACT_SOLVE: begin
                                fs_reg <= 1'b1;
                                if (!fact_reg) begin
                                    sts_reg <= ST_NO_FACTOR;
                                    state_reg <= S_OUT;
                                end else if (sing_reg) begin
                                    sts_reg <= ST_SINGULAR;
                                    state_reg <= S_OUT;
                                end else begin
                                    sts_reg <= ST_OK;
                                    step_reg <= V_Y0;
                                    state_reg <= S_OP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PIV0: begin
                    fact_reg <= 1'b1;
                    if (m0 == '0 && m1 == '0 && m2 == '0) begin
                        piv_reg <= '{2'd0, 2'd1, 2'd2};
                        sing_reg <= 1'b1;
                        sts_reg <= ST_SINGULAR;
                        state_reg <= S_OUT;
                    end else begin
                        if (m1 > m0 && m1 >= m2) p0_reg <= 2'd1;
                        else if (m2 > m0 && m2 > m1) p0_reg <= 2'd2;
                        else p0_reg <= 2'd0;
                        step_reg <= F_D01;
                        state_reg <= S_OP;
                    end
                end
                S_OP: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (done_reg) begin
                        // sequencing
                        case (step_reg)
                            F_S22: step_reg <= F_PIV1;   // stay here for the pivot choice
                            F_S2, V_S5: state_reg <= S_OUT;
                            default: begin
                                state_reg <= S_OP;
                                step_reg <= step_t'(step_reg + 1'b1);
                            end
                        endcase
                        // write-back
                        case (step_reg)
                            F_D01: mat[at(p0_reg,1)] <= res_reg;
                            F_D02: mat[at(p0_reg,2)] <= res_reg;
                            F_S11: mat[at(i1,1)] <= res_reg;
                            F_S12: mat[at(i1,2)] <= res_reg;
                            F_S21: mat[at(i2,1)] <= res_reg;
                            F_S22: mat[at(i2,2)] <= res_reg;
                            F_D12: mat[at(p1_reg,2)] <= res_reg;
                            F_S2: begin
                                mat[at(p2_reg,2)] <= res_reg;
                                sing_reg <= (res_reg == '0);
                                sts_reg <= (res_reg == '0) ? ST_SINGULAR : ST_OK;
                                piv_reg <= '{p0_reg, p1_reg, p2_reg};
                            end
                            V_Y0: t_reg[0] <= res_reg;
                            V_S1: t_reg[1] <= res_reg;
                            V_D1: t_reg[1] <= res_reg;
                            V_S2A: t_reg[2] <= res_reg;
                            V_S2B: t_reg[2] <= res_reg;
                            V_D2: t_reg[2] <= res_reg;
                            V_S3: t_reg[1] <= res_reg;
                            V_S4: t_reg[0] <= res_reg;
                            V_S5: t_reg[0] <= res_reg;
                            default: ;
                        endcase
                    end else if (step_reg == F_PIV1) begin
                        // second pivot choice after the column-1 update
                        if (ma > mb && ma != '0) begin
                            p1_reg <= i1;
                            p2_reg <= i2;
                        end else begin
                            p1_reg <= i2;
                            p2_reg <= i1;
                        end
                        step_reg <= F_END;
                    end else if (step_reg == F_END) begin
                        piv_reg <= '{p0_reg, p1_reg, p2_reg};
                        if (mat[at(p1_reg,1)] == '0) begin
                            sing_reg <= 1'b1;
                            sts_reg <= ST_SINGULAR;
                            state_reg <= S_OUT;
                        end else begin
                            step_reg <= F_D12;
                            state_reg <= S_OP;
                        end
                    end
                end
                S_OUT: begin
                    if (m_hs) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // solutions are zero unless a solve finished ok
    a_zero_on_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != ST_OK |-> m_tdata == '0)
        else $error("nonzero solution with bad status");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("ready while a result waits");
    a_factor_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tuser[1:0] != ST_NO_FACTOR)
        else $error("factor reports missing factors");

endmodule
